// ----- rtl/core/rsld_pkg.sv -----
package rsld_pkg;

   localparam int COORD_BITS  = 12;
   localparam int ADDR_BITS   = 25;
   localparam int STRIDE_BITS = 14;
   localparam int COLOR_BITS  = 8;
   localparam int CNT_BITS    = COORD_BITS + 1;
   localparam int ERR_BITS    = 15;
   localparam int STEP_BITS   = $clog2(COORD_BITS);

   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(640);

   localparam logic [2:0] KIND_VERT   = 3'd0;
   localparam logic [2:0] KIND_HORIZ  = 3'd1;
   localparam logic [2:0] KIND_DIAG   = 3'd2;
   localparam logic [2:0] KIND_YMAJOR = 3'd3;
   localparam logic [2:0] KIND_XMAJOR = 3'd4;

   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_FULL  = 2'd1;
   localparam logic [1:0] PHASE_FINAL = 2'd2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic load;
      logic div_step;
      logic finish;
      logic tick;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic need_div;
   } status_type;

endpackage

// ----- rtl/core/run_slice_line_drawer_unit.sv -----
// channel | direction | handshake        | beat
// req_    | in        | valid / stall    | opcode, endpoints, color
// rsp_    | out       | valid / stall    | pixel address, color, last flag
// csr_    | in        | valid / ready    | line stride
// A tick beat taken while a line is active yields one pixel beat in the next cycle.
// A start beat of a vertical, horizontal or diagonal line loads the engine at once;
// other lines then run the 12-step restoring divider and a finish step.
// Reset is synchronous and restores an idle engine with stride 640.
// req_stall is high while dividing or finishing and while a pixel beat waits on rsp_stall.
module run_slice_line_drawer_unit
   import rsld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   input  logic [COLOR_BITS-1:0]  req_draw_color,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_BITS-1:0]   rsp_pixel_address,
   output logic [COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                   rsp_last_pixel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [STRIDE_BITS-1:0] csr_line_stride
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rsld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   rsld_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_line_stride),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_draw_color    (req_draw_color),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

// ----- rtl/core/rsld_ctrl.sv -----
module rsld_ctrl
   import rsld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_START) begin
               cmd.load = 1'b1;
               step_in  = '0;
               if (status.need_div) begin
                  state_in = ST_DIV;
               end
            end else if (accept && req_opcode == OP_TICK && status.busy) begin
               cmd.tick     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(COORD_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/rsld_dp.sv -----
module rsld_dp
   import rsld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_write,
   input  logic [STRIDE_BITS-1:0] csr_data,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   input  logic [COLOR_BITS-1:0]  req_draw_color,
   output logic [ADDR_BITS-1:0]   rsp_pixel_address,
   output logic [COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                   rsp_last_pixel
);

   logic [STRIDE_BITS-1:0] stride_ff;
   logic [ADDR_BITS-1:0]   offset_ff, offset_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [STRIDE_BITS-1:0] adj_up_ff, adj_up_in, adj_dn_ff, adj_dn_in;
   logic [CNT_BITS-1:0]    whole_ff, whole_in, runs_ff, runs_in;
   logic [CNT_BITS-1:0]    rpl_ff, rpl_in, final_ff, final_in;
   logic [2:0]             kind_ff, kind_in;
   logic                   neg_ff, neg_in;
   logic [1:0]             phase_ff, phase_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;
   logic                   busy_ff, busy_in;
   logic [COORD_BITS-1:0]  minor_ff, minor_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [ADDR_BITS-1:0]   out_addr_ff, out_addr_in;
   logic [COLOR_BITS-1:0]  out_color_ff, out_color_in;
   logic                   out_last_ff, out_last_in;

   logic                   swap, neg_c;
   logic [COORD_BITS-1:0]  x0, y0, x1, y1, dx, dy, major_c, minor_c;
   logic [2:0]             kind_c;
   logic [ADDR_BITS-1:0]   prod;
   logic [COORD_BITS:0]    trial, minor_ext;
   logic                   ge;
   logic signed [ERR_BITS:0] err_fin, err_acc, err_sub;
   logic [CNT_BITS-1:0]    ini, rpl_dec, len;
   logic [ADDR_BITS-1:0]   stride_ext, plus_stride, inner;

   assign swap    = req_start_y > req_end_y;
   assign x0      = swap ? req_end_x : req_start_x;
   assign y0      = swap ? req_end_y : req_start_y;
   assign x1      = swap ? req_start_x : req_end_x;
   assign y1      = swap ? req_start_y : req_end_y;
   assign neg_c   = x1 < x0;
   assign dx      = neg_c ? x0 - x1 : x1 - x0;
   assign dy      = y1 - y0;
   assign major_c = (dx < dy) ? dy : dx;
   assign minor_c = (dx < dy) ? dx : dy;
   assign prod    = ADDR_BITS'(y0) * ADDR_BITS'(stride_ff);

   always_comb begin
      if (dx == '0) begin
         kind_c = KIND_VERT;
      end else if (dy == '0) begin
         kind_c = KIND_HORIZ;
      end else if (dx == dy) begin
         kind_c = KIND_DIAG;
      end else if (dx < dy) begin
         kind_c = KIND_YMAJOR;
      end else begin
         kind_c = KIND_XMAJOR;
      end
   end

   assign status.busy     = busy_ff;
   assign status.need_div = kind_c >= KIND_YMAJOR;

   assign minor_ext = {1'b0, minor_ff};
   assign trial     = {rem_ff, quo_ff[COORD_BITS-1]};
   assign ge        = trial >= minor_ext;

   assign err_fin = (ERR_BITS + 1)'(rem_ff) - (ERR_BITS + 1)'({minor_ff, 1'b0})
                    + (quo_ff[0] ? (ERR_BITS + 1)'(minor_ff) : '0);
   assign ini     = CNT_BITS'(quo_ff >> 1) + 1'b1;

   assign stride_ext  = ADDR_BITS'(stride_ff);
   assign plus_stride = offset_ff + stride_ext;
   assign rpl_dec     = (rpl_ff != '0) ? rpl_ff - 1'b1 : '0;
   assign err_acc     = (ERR_BITS + 1)'(err_ff) + (ERR_BITS + 1)'(adj_up_ff);
   assign err_sub     = err_acc - (ERR_BITS + 1)'(adj_dn_ff);
   assign len         = whole_ff + ((err_acc > 0) ? 1'b1 : 1'b0);

   function automatic logic [ADDR_BITS-1:0] add_dir(input logic [ADDR_BITS-1:0] v,
                                                    input logic n);
      add_dir = n ? v - 1'b1 : v + 1'b1;
   endfunction

   always_comb begin
      case (kind_ff)
         KIND_VERT, KIND_YMAJOR: inner = plus_stride;
         KIND_HORIZ, KIND_XMAJOR: inner = add_dir(offset_ff, neg_ff);
         default: inner = add_dir(plus_stride, neg_ff);
      endcase
   end

   always_comb begin
      offset_in    = offset_ff;
      err_in       = err_ff;
      adj_up_in    = adj_up_ff;
      adj_dn_in    = adj_dn_ff;
      whole_in     = whole_ff;
      runs_in      = runs_ff;
      rpl_in       = rpl_ff;
      final_in     = final_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      phase_in     = phase_ff;
      color_in     = color_ff;
      busy_in      = busy_ff;
      minor_in     = minor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (cmd.load) begin
         offset_in = prod + ADDR_BITS'(x0);
         color_in  = req_draw_color;
         neg_in    = neg_c;
         kind_in   = kind_c;
         busy_in   = 1'b1;
         phase_in  = PHASE_FINAL;
         runs_in   = '0;
         err_in    = '0;
         adj_up_in = '0;
         adj_dn_in = '0;
         whole_in  = '0;
         rpl_in    = (kind_c == KIND_VERT) ? CNT_BITS'(dy) + 1'b1 : CNT_BITS'(dx) + 1'b1;
         final_in  = rpl_in;
         minor_in  = minor_c;
         rem_in    = '0;
         quo_in    = major_c;
      end
      if (cmd.div_step) begin
         rem_in = ge ? COORD_BITS'(trial - minor_ext) : trial[COORD_BITS-1:0];
         quo_in = {quo_ff[COORD_BITS-2:0], ge};
      end
      if (cmd.finish) begin
         whole_in  = CNT_BITS'(quo_ff);
         adj_up_in = STRIDE_BITS'({rem_ff, 1'b0});
         adj_dn_in = STRIDE_BITS'({minor_ff, 1'b0});
         err_in    = err_fin[ERR_BITS-1:0];
         final_in  = ini;
         rpl_in    = (rem_ff == '0 && !quo_ff[0]) ? ini - 1'b1 : ini;
         runs_in   = CNT_BITS'(minor_ff) - 1'b1;
         phase_in  = PHASE_FIRST;
      end
      if (cmd.tick) begin
         out_addr_in  = offset_ff;
         out_color_in = color_ff;
         out_last_in  = 1'b0;
         rpl_in       = rpl_dec;
         if (rpl_dec != '0) begin
            offset_in = inner;
         end else if (phase_ff == PHASE_FINAL) begin
            out_last_in = 1'b1;
            busy_in     = 1'b0;
         end else begin
            offset_in = add_dir(plus_stride, neg_ff);
            if (runs_ff != '0) begin
               phase_in = PHASE_FULL;
               rpl_in   = len;
               err_in   = (err_acc > 0) ? err_sub[ERR_BITS-1:0] : err_acc[ERR_BITS-1:0];
               runs_in  = runs_ff - 1'b1;
            end else begin
               phase_in = PHASE_FINAL;
               rpl_in   = final_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
         offset_ff <= '0;
         err_ff    <= '0;
         adj_up_ff <= '0;
         adj_dn_ff <= '0;
         whole_ff  <= '0;
         runs_ff   <= '0;
         rpl_ff    <= '0;
         final_ff  <= '0;
         kind_ff   <= KIND_VERT;
         neg_ff    <= 1'b0;
         phase_ff  <= PHASE_FIRST;
         color_ff  <= '0;
         busy_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            stride_ff <= csr_data;
         end
         offset_ff <= offset_in;
         err_ff    <= err_in;
         adj_up_ff <= adj_up_in;
         adj_dn_ff <= adj_dn_in;
         whole_ff  <= whole_in;
         runs_ff   <= runs_in;
         rpl_ff    <= rpl_in;
         final_ff  <= final_in;
         kind_ff   <= kind_in;
         neg_ff    <= neg_in;
         phase_ff  <= phase_in;
         color_ff  <= color_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      minor_ff     <= minor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_pixel    = out_last_ff;

endmodule

// ----- rtl/core/rsld_checker.sv -----
module rsld_checker
   import rsld_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_opcode,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ADDR_BITS-1:0] rsp_pixel_address
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_address);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp beat dropped while stalled");

   property p_reset_idle;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_idle: assert property (p_reset_idle) else $error("rsp valid after reset");

   property p_start_silent;
      @(posedge clock) disable iff (reset)
         req_valid && !req_stall && req_opcode == OP_START && !rsp_valid |=> !rsp_valid;
   endproperty
   a_start_silent: assert property (p_start_silent) else $error("start beat made a pixel");

   property p_stall_backpressure;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |-> req_stall;
   endproperty
   a_stall_backpressure: assert property (p_stall_backpressure)
      else $error("req taken while rsp blocked");

endmodule

bind run_slice_line_drawer_unit rsld_checker u_rsld_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_address (rsp_pixel_address)
);
